[hw/rtl/stage_latency_stats_monitor_macros.svh]
// Assertion macros used by the latency statistics monitor sequencer.
`ifndef STAGE_LATENCY_STATS_MONITOR_MACROS_SVH
`define STAGE_LATENCY_STATS_MONITOR_MACROS_SVH

// Combinational or implication property checked at every rising clock edge.
`define SLSM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("slsm assertion failed");

// Property whose consequent is checked in the cycle after the antecedent.
`define SLSM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slsm assertion failed");

`endif

[hw/rtl/slsm_pkg.sv]
// Shared types and constants for the latency statistics monitor.
`timescale 1ns / 1ps
package slsm_pkg;

   localparam int NUM_STAGES = 7;
   localparam int IDX_W      = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;

   localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
   localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

   localparam logic [31:0] SLOW_THR_RESET = 32'd50000;
   localparam logic [31:0] INTERVAL_RESET = 32'd5000;

   localparam logic CMD_RECORD = 1'b0;
   localparam logic CMD_REPORT = 1'b1;

   typedef enum logic [1:0] {
      CSR_ENABLED  = 2'd0,
      CSR_SLOW_THR = 2'd1,
      CSR_INTERVAL = 2'd2
   } csr_index_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_TOTAL,
      S_COUNT,
      S_MAX,
      S_SLOW_CMP,
      S_SLOW_INC,
      S_ELAPSED,
      S_DUE,
      S_EMIT
   } seq_state_type;

   typedef struct packed {
      logic             count_we;
      logic             total_we;
      logic             max_we;
      logic             slow_we;
      logic             clear;
      logic [IDX_W-1:0] idx;
      logic [31:0]      count;
      logic [47:0]      total;
      logic [31:0]      max;
      logic [31:0]      slow;
   } stats_wr_type;

   typedef struct packed {
      logic [31:0] count;
      logic [47:0] total;
      logic [31:0] max;
      logic [31:0] slow;
   } stats_rd_type;

   typedef struct packed {
      logic        last;
      logic [47:0] interval_ms;
      logic [31:0] slow_count;
      logic [31:0] max_us;
      logic [47:0] total_us;
      logic [31:0] sample_count;
      logic [2:0]  stage_index;
   } rsp_type;

   typedef struct packed {
      logic        command;
      logic [2:0]  stage;
      logic [31:0] duration_us;
      logic [47:0] now_ms;
      logic        force_req;
   } req_type;

   typedef struct packed {
      logic        enabled;
      logic        clear;
      logic [31:0] slow_thr;
      logic [31:0] interval;
   } cfg_type;

endpackage

[hw/rtl/stage_latency_stats_monitor.sv]
// Record: request accepted in idle; if enabled and the stage is in range, the shared-adder steps
// total, count, max, slow compare and slow increment run before idle takes the next request.
// Report: elapsed and due checks, then, if due or forced, one result per stage each cycle the
// output register is free. Statistics and report time arithmetic use one 48-bit add/subtract unit.
// Reset is synchronous: gathering off, thresholds to defaults, all statistics and the
// last report time cleared at once; no clearing pass is needed.
`timescale 1ns / 1ps
module stage_latency_stats_monitor
   import slsm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [87:0]  req_tdata,  // stage[2:0], duration_us[34:3], now_ms[82:35], force_req[83]
   input  logic         req_tuser,  // command[0]
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [199:0] rsp_tdata,  // stage_index[2:0], sample_count[34:3], total_us[82:35],
                                    // max_us[114:83], slow_count[146:115], interval_ms[194:147]
   output logic         rsp_tlast,
   // configuration write channel
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data
);

   logic        enabled_ff, enabled_in;
   logic [31:0] slow_thr_ff, slow_thr_in;
   logic [31:0] interval_ff, interval_in;
   logic        csr_write;
   cfg_type     cfg;
   req_type     req;
   rsp_type     rsp;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      enabled_in  = enabled_ff;
      slow_thr_in = slow_thr_ff;
      interval_in = interval_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_ENABLED:  enabled_in  = csr_data[0];
            CSR_SLOW_THR: slow_thr_in = csr_data;
            CSR_INTERVAL: interval_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff  <= 1'b0;
         slow_thr_ff <= SLOW_THR_RESET;
         interval_ff <= INTERVAL_RESET;
      end else begin
         enabled_ff  <= enabled_in;
         slow_thr_ff <= slow_thr_in;
         interval_ff <= interval_in;
      end
   end

   // Any write to the enable register wipes the statistics and the report time.
   assign cfg.enabled  = enabled_ff;
   assign cfg.clear    = csr_write && (csr_index == CSR_ENABLED);
   assign cfg.slow_thr = slow_thr_ff;
   assign cfg.interval = interval_ff;

   assign req.command     = req_tuser;
   assign req.stage       = req_tdata[2:0];
   assign req.duration_us = req_tdata[34:3];
   assign req.now_ms      = req_tdata[82:35];
   assign req.force_req   = req_tdata[83];

   slsm_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = {5'b0, rsp.interval_ms, rsp.slow_count, rsp.max_us,
                       rsp.total_us, rsp.sample_count, rsp.stage_index};
   assign rsp_tlast = rsp.last;

endmodule

[hw/rtl/slsm_alu.sv]
// Shared 48-bit add/subtract unit; bit 48 of the result is carry or borrow.
`timescale 1ns / 1ps
module slsm_alu
   import slsm_pkg::*;
(
   input  alu_op_type  op,
   input  logic [47:0] a,
   input  logic [47:0] b,
   output logic [48:0] y
);

   always_comb begin
      case (op)
         ALU_ADD: y = {1'b0, a} + {1'b0, b};
         ALU_SUB: y = {1'b0, a} - {1'b0, b};
         default: y = {1'b0, a} + {1'b0, b};
      endcase
   end

endmodule

[hw/rtl/slsm_stats.sv]
// Per-stage statistics registers with one read port and one write port.
`timescale 1ns / 1ps
module slsm_stats
   import slsm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  stats_wr_type     wr,
   input  logic [IDX_W-1:0] rd_idx,
   output stats_rd_type     rd
);

   logic [31:0] count_ff [NUM_STAGES];
   logic [47:0] total_ff [NUM_STAGES];
   logic [31:0] max_ff   [NUM_STAGES];
   logic [31:0] slow_ff  [NUM_STAGES];

   always_ff @(posedge clock) begin
      if (reset || wr.clear) begin
         for (int i = 0; i < NUM_STAGES; i++) begin
            count_ff[i] <= '0;
            total_ff[i] <= '0;
            max_ff[i]   <= '0;
            slow_ff[i]  <= '0;
         end
      end else begin
         if (wr.count_we) count_ff[wr.idx] <= wr.count;
         if (wr.total_we) total_ff[wr.idx] <= wr.total;
         if (wr.max_we)   max_ff[wr.idx]   <= wr.max;
         if (wr.slow_we)  slow_ff[wr.idx]  <= wr.slow;
      end
   end

   always_comb begin
      rd.count = count_ff[rd_idx];
      rd.total = total_ff[rd_idx];
      rd.max   = max_ff[rd_idx];
      rd.slow  = slow_ff[rd_idx];
   end

endmodule

[hw/rtl/slsm_seq.sv]
// Sequencer that drives the shared arithmetic unit for records and reports.
`timescale 1ns / 1ps
`include "stage_latency_stats_monitor_macros.svh"
module slsm_seq
   import slsm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);

   seq_state_type    state_ff, state_in;
   logic [2:0]       stage_ff, stage_in;
   logic [31:0]      dur_ff, dur_in;
   logic [47:0]      now_ff, now_in;
   logic             force_ff, force_in;
   logic             slow_hit_ff, slow_hit_in;
   logic [47:0]      elapsed_ff, elapsed_in;
   logic [47:0]      last_time_ff, last_time_in;
   logic [IDX_W-1:0] emit_idx_ff, emit_idx_in;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_ff, out_in;

   alu_op_type       alu_op;
   logic [47:0]      alu_a;
   logic [47:0]      alu_b;
   logic [48:0]      alu_y;
   stats_wr_type     wr;
   logic [IDX_W-1:0] rd_idx;
   stats_rd_type     rd;
   logic             emit_last;

   slsm_alu u_alu (
      .op (alu_op),
      .a  (alu_a),
      .b  (alu_b),
      .y  (alu_y)
   );

   slsm_stats u_stats (
      .clock  (clock),
      .reset  (reset),
      .wr     (wr),
      .rd_idx (rd_idx),
      .rd     (rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         last_time_ff <= '0;
         out_valid_ff <= 1'b0;
         emit_idx_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         last_time_ff <= last_time_in;
         out_valid_ff <= out_valid_in;
         emit_idx_ff  <= emit_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff    <= stage_in;
      dur_ff      <= dur_in;
      now_ff      <= now_in;
      force_ff    <= force_in;
      slow_hit_ff <= slow_hit_in;
      elapsed_ff  <= elapsed_in;
      out_ff      <= out_in;
   end

   assign emit_last = (emit_idx_ff == IDX_W'(NUM_STAGES - 1));
   assign rd_idx    = (state_ff == S_EMIT) ? emit_idx_ff : stage_ff[IDX_W-1:0];

   always_comb begin
      state_in     = state_ff;
      stage_in     = stage_ff;
      dur_in       = dur_ff;
      now_in       = now_ff;
      force_in     = force_ff;
      slow_hit_in  = slow_hit_ff;
      elapsed_in   = elapsed_ff;
      last_time_in = cfg.clear ? '0 : last_time_ff;
      emit_idx_in  = emit_idx_ff;
      out_in       = out_ff;
      out_valid_in = (out_valid_ff && !rsp_ready) ? 1'b1 : 1'b0;
      req_ready    = 1'b0;
      alu_op       = ALU_ADD;
      alu_a        = '0;
      alu_b        = '0;
      wr           = '0;
      wr.idx       = stage_ff[IDX_W-1:0];
      wr.clear     = cfg.clear;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               stage_in    = req.stage;
               dur_in      = req.duration_us;
               now_in      = req.now_ms;
               force_in    = req.force_req;
               emit_idx_in = '0;
               if (cfg.enabled) begin
                  if (req.command == CMD_REPORT) begin
                     state_in = S_ELAPSED;
                  end else if ({1'b0, req.stage} < 4'(NUM_STAGES)) begin
                     state_in = S_TOTAL;
                  end
               end
            end
         end
         S_TOTAL: begin
            alu_a       = rd.total;
            alu_b       = {16'b0, dur_ff};
            wr.total_we = 1'b1;
            wr.total    = alu_y[48] ? MAX48 : alu_y[47:0];
            state_in    = S_COUNT;
         end
         S_COUNT: begin
            alu_a       = {16'b0, rd.count};
            alu_b       = 48'd1;
            wr.count_we = 1'b1;
            wr.count    = alu_y[32] ? MAX32 : alu_y[31:0];
            state_in    = S_MAX;
         end
         S_MAX: begin
            // A borrow from max minus duration means the new sample is larger.
            alu_op    = ALU_SUB;
            alu_a     = {16'b0, rd.max};
            alu_b     = {16'b0, dur_ff};
            wr.max_we = alu_y[48];
            wr.max    = dur_ff;
            state_in  = S_SLOW_CMP;
         end
         S_SLOW_CMP: begin
            alu_op      = ALU_SUB;
            alu_a       = {16'b0, dur_ff};
            alu_b       = {16'b0, cfg.slow_thr};
            slow_hit_in = !alu_y[48];
            state_in    = S_SLOW_INC;
         end
         S_SLOW_INC: begin
            alu_a      = {16'b0, rd.slow};
            alu_b      = 48'd1;
            wr.slow_we = slow_hit_ff;
            wr.slow    = alu_y[32] ? MAX32 : alu_y[31:0];
            state_in   = S_IDLE;
         end
         S_ELAPSED: begin
            alu_op     = ALU_SUB;
            alu_a      = now_ff;
            alu_b      = last_time_ff;
            elapsed_in = alu_y[47:0];
            state_in   = S_DUE;
         end
         S_DUE: begin
            alu_op = ALU_SUB;
            alu_a  = elapsed_ff;
            alu_b  = {16'b0, cfg.interval};
            if (force_ff || !alu_y[48]) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in        = 1'b1;
               out_in.stage_index  = 3'(emit_idx_ff);
               out_in.sample_count = rd.count;
               out_in.total_us     = rd.total;
               out_in.max_us       = rd.max;
               out_in.slow_count   = rd.slow;
               out_in.interval_ms  = elapsed_ff;
               out_in.last         = emit_last;
               if (emit_last) begin
                  wr.clear     = 1'b1;
                  last_time_in = now_ff;
                  state_in     = S_IDLE;
               end else begin
                  emit_idx_in = IDX_W'(emit_idx_ff + 1'b1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

   `SLSM_ASSERT(a_emit_idx_range, clock, reset,
      (state_ff == S_EMIT) |-> ({1'b0, emit_idx_ff} < (IDX_W + 1)'(NUM_STAGES)))
   `SLSM_ASSERT(a_record_stage_range, clock, reset,
      (state_ff == S_TOTAL || state_ff == S_COUNT || state_ff == S_MAX)
         |-> ({1'b0, stage_ff} < 4'(NUM_STAGES)))
   `SLSM_ASSERT(a_last_is_final_stage, clock, reset,
      (out_valid_ff && out_ff.last) |-> (out_ff.stage_index == 3'(NUM_STAGES - 1)))
   `SLSM_ASSERT_NEXT(a_final_emit_ends_report, clock, reset,
      (state_ff == S_EMIT && emit_last && (!out_valid_ff || rsp_ready)),
      (state_ff == S_IDLE && out_valid_ff && out_ff.last))

endmodule
